[src/scp_pkg.sv]
package scp_pkg;

  localparam int MaxElectrodes = 32;
  localparam int IdxW          = 5;
  localparam int CntW          = 6;

  localparam logic [20:0] TimeoutTicks = 21'd2000000;
  localparam logic [19:0] PeriodScale  = 20'd1000000;
  localparam logic [11:0] PatternMax   = 12'd4095;

  localparam logic [1:0] FuncByte   = 2'd0;
  localparam logic [1:0] FuncTick   = 2'd1;
  localparam logic [1:0] FuncSample = 2'd2;

  localparam logic [3:0] CmdMode      = 4'd0;
  localparam logic [3:0] CmdPattern   = 4'd1;
  localparam logic [3:0] CmdPolarity  = 4'd2;
  localparam logic [3:0] CmdPulse     = 4'd3;
  localparam logic [3:0] CmdSenseH    = 4'd4;
  localparam logic [3:0] CmdSenseW    = 4'd5;
  localparam logic [3:0] CmdDischarge = 4'd6;
  localparam logic [3:0] CmdFreq      = 4'd7;
  localparam logic [3:0] CmdElectr    = 4'd8;
  localparam logic [3:0] CmdMeasure   = 4'd9;
  localparam logic [3:0] CmdDrivers   = 4'd10;
  localparam logic [3:0] CmdSync      = 4'd11;

  localparam logic KindByte    = 1'b0;
  localparam logic KindSetting = 1'b1;

  typedef struct packed {
    logic        start;
    logic [19:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [19:0] quotient;
  } div_rsp_t;

endpackage

[src/scp_divider.sv]
module scp_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scp_pkg::div_req_t req_i,
  output scp_pkg::div_rsp_t rsp_o
);
  import scp_pkg::*;

  logic [19:0] rem_q, rem_d, quo_q, quo_d, div_q, div_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [20:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q, PeriodScale[5'd19 - cnt_q]} - {1'b0, div_q};
    if (req_i.start) begin
      rem_d = '0;
      quo_d = '0;
      div_d = req_i.divisor;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[20]) begin
        rem_d = trial[19:0];
        quo_d = {quo_q[18:0], 1'b1};
      end else begin
        rem_d = {rem_q[18:0], PeriodScale[5'd19 - cnt_q]};
        quo_d = {quo_q[18:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd19) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

[src/stimulation_command_parser_top.sv]
// Stimulation command parser. Each input beat is a received byte, a
// microsecond tick or an ADC sample to store. A completed single setting
// or query sends its one result the cycle after decode. A measure dump (up
// to 64 beats) or a pattern (up to 32) sends each beat after an address
// step and a registered read, and holds it until the sink takes it. The
// frequency command runs a restoring divider, one quotient bit per cycle,
// before its period beat. s_axis_tready is low from the accepted beat until
// it has been decoded and its last result, if any, has been taken.
module stimulation_command_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte, [12:8] sample_channel, [28:13] sample_value
  input  logic [31:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [11:8] setting_id, [16:12] setting_index,
  // [36:17] setting_value
  output logic [39:0] m_axis_tdata,
  // [0] kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import scp_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDecode, StMeasure, StPattern, StDivide, StEmit
  } state_e;

  state_e state_q;
  logic [7:0]  drv_q;
  logic        busy_q;
  logic [3:0]  cmd_q;
  logic [6:0]  need_q, seen_q;
  logic [7:0]  low_q;
  logic [20:0] ticks_q;
  logic [CntW-1:0] ecount_q;
  logic [1:0]  func_q;
  logic [7:0]  byte_q;
  logic [IdxW-1:0] chan_q;
  logic [15:0] samp_q;
  logic [15:0] sample_mem [MaxElectrodes];
  logic [MaxElectrodes-1:0] smp_vld_q;
  logic [11:0] pat_mem [MaxElectrodes];
  logic [15:0] samp_rd_q;
  logic [11:0] pat_rd_q;
  logic [CntW:0] iter_q;
  logic        hi_q;
  logic        rd_ok_q;
  logic        ovalid_q, olast_q, okind_q;
  logic [7:0]  odata_q;
  logic [3:0]  oid_q;
  logic [IdxW-1:0] oidx_q;
  logic [19:0] oval_q;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [15:0] word;
  logic [6:0]  seen_n;

  assign word   = {byte_q, low_q};
  assign seen_n = seen_q + 7'd1;
  assign dreq.divisor = {4'd0, word};
  assign dreq.start   = (state_q == StDecode) && func_q == FuncByte && busy_q
                        && cmd_q == CmdFreq && seen_n >= need_q && word != 16'd0;

  scp_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'd0, oval_q, oidx_q, oid_q, odata_q};
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

  always_ff @(posedge clk_i) begin
    if (state_q == StDecode && func_q == FuncSample) sample_mem[chan_q] <= samp_q;
    if (state_q == StDecode && func_q == FuncByte && busy_q && cmd_q == CmdPattern
        && seen_q[0]) begin
      pat_mem[seen_q[IdxW:1]] <= (word > {4'd0, PatternMax}) ? PatternMax : word[11:0];
    end
    samp_rd_q <= smp_vld_q[iter_q[IdxW-1:0]] ? sample_mem[iter_q[IdxW-1:0]] : '0;
    pat_rd_q  <= pat_mem[iter_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= '0;
    end else if (state_q == StDecode && func_q == FuncSample) begin
      smp_vld_q[chan_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      drv_q    <= '0;
      busy_q   <= 1'b0;
      cmd_q    <= '0;
      need_q   <= '0;
      seen_q   <= '0;
      low_q    <= '0;
      ticks_q  <= '0;
      ecount_q <= '0;
      func_q   <= '0;
      byte_q   <= '0;
      chan_q   <= '0;
      samp_q   <= '0;
      iter_q   <= '0;
      hi_q     <= 1'b0;
      rd_ok_q  <= 1'b0;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
      okind_q  <= 1'b0;
      odata_q  <= '0;
      oid_q    <= '0;
      oidx_q   <= '0;
      oval_q   <= '0;
    end else begin
      if (cfg_we_i) drv_q <= cfg_wdata_i;
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            func_q  <= s_axis_tuser;
            byte_q  <= s_axis_tdata[7:0];
            chan_q  <= s_axis_tdata[12:8];
            samp_q  <= s_axis_tdata[28:13];
            state_q <= StDecode;
          end
        end
        StDecode: begin
          state_q <= StIdle;
          okind_q <= KindSetting;
          odata_q <= '0;
          oidx_q  <= '0;
          olast_q <= 1'b1;
          rd_ok_q <= 1'b0;
          if (func_q == FuncTick && busy_q) begin
            if (ticks_q >= TimeoutTicks) begin
              busy_q <= 1'b0; cmd_q <= '0; need_q <= '0; seen_q <= '0;
              low_q <= '0; ticks_q <= '0;
            end else begin
              ticks_q <= ticks_q + 21'd1;
            end
          end else if (func_q == FuncByte && busy_q) begin
            if (cmd_q == CmdPattern) begin
              if (!seen_q[0]) low_q <= byte_q;
            end else if (seen_q == 7'd0 && need_q == 7'd2) begin
              low_q <= byte_q;
            end
            seen_q <= seen_n;
            if (seen_n >= need_q) begin
              busy_q <= 1'b0; cmd_q <= '0; need_q <= '0; seen_q <= '0;
              low_q <= '0; ticks_q <= '0;
              oid_q <= cmd_q;
              unique case (cmd_q)
                CmdMode: begin
                  oval_q <= (byte_q > 8'd2) ? 20'd2 : {12'd0, byte_q};
                  ovalid_q <= 1'b1; state_q <= StEmit;
                end
                CmdPolarity: begin
                  oval_q <= (byte_q > 8'd1) ? 20'd1 : {12'd0, byte_q};
                  ovalid_q <= 1'b1; state_q <= StEmit;
                end
                CmdPulse: begin
                  oval_q <= {4'd0, word}; ovalid_q <= 1'b1; state_q <= StEmit;
                end
                CmdSenseH, CmdSenseW, CmdDischarge: begin
                  oval_q <= {12'd0, byte_q}; ovalid_q <= 1'b1; state_q <= StEmit;
                end
                CmdElectr: begin
                  ecount_q <= (byte_q > 8'(MaxElectrodes)) ? CntW'(MaxElectrodes)
                                                          : byte_q[CntW-1:0];
                  oval_q <= (byte_q > 8'(MaxElectrodes)) ? 20'(MaxElectrodes)
                                                         : {12'd0, byte_q};
                  ovalid_q <= 1'b1; state_q <= StEmit;
                end
                CmdFreq: begin
                  if (word != 16'd0) state_q <= StDivide;
                end
                CmdPattern: begin
                  iter_q  <= '0;
                  state_q <= StPattern;
                end
                default: ;
              endcase
            end
          end else if (func_q == FuncByte) begin
            okind_q <= KindByte;
            oid_q   <= '0;
            oval_q  <= '0;
            unique case (byte_q[3:0])
              CmdMode, CmdPolarity, CmdSenseH, CmdSenseW, CmdDischarge, CmdElectr: begin
                if (byte_q[7:4] == 4'd0) begin
                  busy_q <= 1'b1; cmd_q <= byte_q[3:0]; need_q <= 7'd1;
                  seen_q <= '0; low_q <= '0; ticks_q <= '0;
                end
              end
              CmdPulse, CmdFreq: begin
                if (byte_q[7:4] == 4'd0) begin
                  busy_q <= 1'b1; cmd_q <= byte_q[3:0]; need_q <= 7'd2;
                  seen_q <= '0; low_q <= '0; ticks_q <= '0;
                end
              end
              CmdPattern: begin
                if (byte_q[7:4] == 4'd0 && ecount_q != '0) begin
                  busy_q <= 1'b1; cmd_q <= CmdPattern; need_q <= {ecount_q, 1'b0};
                  seen_q <= '0; low_q <= '0; ticks_q <= '0;
                end
              end
              CmdMeasure: begin
                if (byte_q[7:4] == 4'd0 && ecount_q != '0) begin
                  iter_q <= '0; hi_q <= 1'b0; state_q <= StMeasure;
                end
              end
              CmdDrivers: begin
                if (byte_q[7:4] == 4'd0) begin
                  odata_q <= drv_q; ovalid_q <= 1'b1; state_q <= StEmit;
                end
              end
              CmdSync: begin
                if (byte_q[7:4] == 4'd0) begin
                  odata_q <= {2'd0, ecount_q}; ovalid_q <= 1'b1; state_q <= StEmit;
                end
              end
              default: ;
            endcase
          end
        end
        StMeasure: begin
          // read data registered the cycle after iter_q settles
          if (!ovalid_q) begin
            if (!rd_ok_q) begin
              rd_ok_q <= 1'b1;
            end else begin
              okind_q  <= KindByte;
              oid_q    <= '0;
              oval_q   <= '0;
              oidx_q   <= '0;
              odata_q  <= hi_q ? samp_rd_q[15:8] : samp_rd_q[7:0];
              olast_q  <= hi_q && (iter_q + 1'b1 == {1'b0, ecount_q});
              ovalid_q <= 1'b1;
            end
          end else if (m_axis_tready) begin
            ovalid_q <= 1'b0;
            rd_ok_q  <= 1'b0;
            if (olast_q) begin
              state_q <= StIdle;
            end else begin
              if (hi_q) iter_q <= iter_q + 1'b1;
              hi_q <= !hi_q;
            end
          end
        end
        StPattern: begin
          if (!ovalid_q) begin
            if (!rd_ok_q) begin
              rd_ok_q <= 1'b1;
            end else begin
              okind_q  <= KindSetting;
              odata_q  <= '0;
              oid_q    <= CmdPattern;
              oidx_q   <= iter_q[IdxW-1:0];
              oval_q   <= {8'd0, pat_rd_q};
              olast_q  <= (iter_q + 1'b1 == {1'b0, ecount_q});
              ovalid_q <= 1'b1;
            end
          end else if (m_axis_tready) begin
            ovalid_q <= 1'b0;
            rd_ok_q  <= 1'b0;
            if (olast_q) state_q <= StIdle;
            else         iter_q <= iter_q + 1'b1;
          end
        end
        StDivide: begin
          if (drsp.done) begin
            oid_q    <= CmdFreq;
            oval_q   <= drsp.quotient;
            ovalid_q <= 1'b1;
            state_q  <= StEmit;
          end
        end
        StEmit: begin
          if (m_axis_tready) begin
            ovalid_q <= 1'b0;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
